[design/fpsp_pkg.sv]
// ----------------------------------------------------------------------------
// fpsp_pkg
// Shared types and constants of the printf format specifier parser: input
// kinds, character classes, character codes, token types, size codes and the
// token record that travels from the parse engine to the result register.
// ----------------------------------------------------------------------------
package fpsp_pkg;

   localparam int ARG_INDEX_BITS_DEF = 8;
   localparam int CHAR_TABLE_LEN_DEF = 123;

   localparam int CODE_BITS      = 21;
   localparam int KIND_BITS      = 2;
   localparam int ARG_FIELD_BITS = 8;
   localparam int REQ_TDATA_BITS = 24;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_TDATA_BITS = 80;
   localparam int RSP_TUSER_BITS = 2;

   // Input item kinds.
   localparam logic [KIND_BITS-1:0] KIND_CHAR    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_END     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd2;

   // Character classes seen by the transition table.
   typedef enum logic [3:0] {
      C_END, C_PCT, C_FLAG, C_NUM, C_STAR, C_DOT, C_SIZE, C_TYPE, C_ZERO
   } char_class_type;

   // Character codes (7-bit, the table never covers more).
   localparam logic [6:0] CH_SPACE = 7'h20; // ' '
   localparam logic [6:0] CH_HASH  = 7'h23; // '#'
   localparam logic [6:0] CH_PCT   = 7'h25; // '%'
   localparam logic [6:0] CH_STAR  = 7'h2A; // '*'
   localparam logic [6:0] CH_PLUS  = 7'h2B; // '+'
   localparam logic [6:0] CH_MINUS = 7'h2D; // '-'
   localparam logic [6:0] CH_DOT   = 7'h2E; // '.'
   localparam logic [6:0] CH_ZERO  = 7'h30; // '0'
   localparam logic [6:0] CH_ONE   = 7'h31; // '1'
   localparam logic [6:0] CH_NINE  = 7'h39; // '9'
   localparam logic [6:0] CH_UA    = 7'h41; // 'A'
   localparam logic [6:0] CH_UE    = 7'h45; // 'E'
   localparam logic [6:0] CH_UF    = 7'h46; // 'F'
   localparam logic [6:0] CH_UG    = 7'h47; // 'G'
   localparam logic [6:0] CH_UL    = 7'h4C; // 'L'
   localparam logic [6:0] CH_UX    = 7'h58; // 'X'
   localparam logic [6:0] CH_A     = 7'h61; // 'a'
   localparam logic [6:0] CH_C     = 7'h63; // 'c'
   localparam logic [6:0] CH_D     = 7'h64; // 'd'
   localparam logic [6:0] CH_E     = 7'h65; // 'e'
   localparam logic [6:0] CH_F     = 7'h66; // 'f'
   localparam logic [6:0] CH_G     = 7'h67; // 'g'
   localparam logic [6:0] CH_H     = 7'h68; // 'h'
   localparam logic [6:0] CH_I     = 7'h69; // 'i'
   localparam logic [6:0] CH_J     = 7'h6A; // 'j'
   localparam logic [6:0] CH_L     = 7'h6C; // 'l'
   localparam logic [6:0] CH_N     = 7'h6E; // 'n'
   localparam logic [6:0] CH_O     = 7'h6F; // 'o'
   localparam logic [6:0] CH_P     = 7'h70; // 'p'
   localparam logic [6:0] CH_S     = 7'h73; // 's'
   localparam logic [6:0] CH_T     = 7'h74; // 't'
   localparam logic [6:0] CH_U     = 7'h75; // 'u'
   localparam logic [6:0] CH_X     = 7'h78; // 'x'
   localparam logic [6:0] CH_Z     = 7'h7A; // 'z'

   // Token types.
   localparam logic [3:0] TT_LITERAL = 4'd0;
   localparam logic [3:0] TT_ESCAPE  = 4'd1;
   localparam logic [3:0] TT_SDEC    = 4'd2;
   localparam logic [3:0] TT_OCT     = 4'd3;
   localparam logic [3:0] TT_UDEC    = 4'd4;
   localparam logic [3:0] TT_HEX     = 4'd5;
   localparam logic [3:0] TT_F       = 4'd6;
   localparam logic [3:0] TT_E       = 4'd7;
   localparam logic [3:0] TT_G       = 4'd8;
   localparam logic [3:0] TT_A       = 4'd9;
   localparam logic [3:0] TT_C       = 4'd10;
   localparam logic [3:0] TT_S       = 4'd11;
   localparam logic [3:0] TT_P       = 4'd12;
   localparam logic [3:0] TT_N       = 4'd13;

   // Size modifiers.
   localparam logic [3:0] SZ_NORMAL = 4'd0;
   localparam logic [3:0] SZ_H      = 4'd1;
   localparam logic [3:0] SZ_HH     = 4'd2;
   localparam logic [3:0] SZ_L      = 4'd3;
   localparam logic [3:0] SZ_LL     = 4'd4;
   localparam logic [3:0] SZ_BIG_L  = 4'd5;
   localparam logic [3:0] SZ_Z      = 4'd6;
   localparam logic [3:0] SZ_J      = 4'd7;
   localparam logic [3:0] SZ_T      = 4'd8;

   // Flag bit positions.
   localparam int FLAG_LEFT  = 0;
   localparam int FLAG_PLUS  = 1;
   localparam int FLAG_SPACE = 2;
   localparam int FLAG_ZERO  = 3;
   localparam int FLAG_ALT   = 4;
   localparam int FLAG_UPPER = 5;

   // Width and precision sources.
   localparam logic [1:0] MODE_DEFAULT = 2'd0;
   localparam logic [1:0] MODE_LITERAL = 2'd1;
   localparam logic [1:0] MODE_ARG     = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   localparam logic [15:0] VALUE_MAX = 16'hFFFF;

   typedef struct packed {
      logic [ARG_FIELD_BITS-1:0] value_arg;
      logic [ARG_FIELD_BITS-1:0] precision_arg;
      logic [1:0]                precision_mode;
      logic [15:0]               precision_value;
      logic [ARG_FIELD_BITS-1:0] width_arg;
      logic [1:0]                width_mode;
      logic [15:0]               width_value;
      logic [3:0]                size_mod;
      logic [5:0]                flag_bits;
      logic [3:0]                token_type;
   } token_record_type;

   typedef struct packed {
      logic             include_char;
      logic             emit;
      token_record_type rec;
   } parse_result_type;

endpackage

[design/fpsp_classify.sv]
// ----------------------------------------------------------------------------
// fpsp_classify
// Maps a character code to the class that indexes the transition table.
// ----------------------------------------------------------------------------
module fpsp_classify #(
   parameter int CHAR_TABLE_LEN = fpsp_pkg::CHAR_TABLE_LEN_DEF
) (
   input  logic [fpsp_pkg::CODE_BITS-1:0] code,
   output fpsp_pkg::char_class_type       cls
);

   localparam logic [fpsp_pkg::CODE_BITS-1:0] TABLE_END =
      fpsp_pkg::CODE_BITS'(CHAR_TABLE_LEN);

   always_comb begin
      if (code >= TABLE_END) begin
         cls = fpsp_pkg::C_END;
      end else begin
         unique case (code[6:0]) inside
            fpsp_pkg::CH_SPACE, fpsp_pkg::CH_HASH,
            fpsp_pkg::CH_PLUS, fpsp_pkg::CH_MINUS:   cls = fpsp_pkg::C_FLAG;
            fpsp_pkg::CH_PCT:                        cls = fpsp_pkg::C_PCT;
            fpsp_pkg::CH_STAR:                       cls = fpsp_pkg::C_STAR;
            fpsp_pkg::CH_DOT:                        cls = fpsp_pkg::C_DOT;
            fpsp_pkg::CH_ZERO:                       cls = fpsp_pkg::C_ZERO;
            [fpsp_pkg::CH_ONE:fpsp_pkg::CH_NINE]:    cls = fpsp_pkg::C_NUM;
            fpsp_pkg::CH_UL, fpsp_pkg::CH_H, fpsp_pkg::CH_J,
            fpsp_pkg::CH_L, fpsp_pkg::CH_T, fpsp_pkg::CH_Z: cls = fpsp_pkg::C_SIZE;
            fpsp_pkg::CH_UA, fpsp_pkg::CH_UE, fpsp_pkg::CH_UF,
            fpsp_pkg::CH_UG, fpsp_pkg::CH_UX,
            fpsp_pkg::CH_A, fpsp_pkg::CH_C, fpsp_pkg::CH_D,
            fpsp_pkg::CH_E, fpsp_pkg::CH_F, fpsp_pkg::CH_G,
            fpsp_pkg::CH_I, fpsp_pkg::CH_N, fpsp_pkg::CH_O,
            fpsp_pkg::CH_P, fpsp_pkg::CH_S, fpsp_pkg::CH_U,
            fpsp_pkg::CH_X:                          cls = fpsp_pkg::C_TYPE;
            default:                                 cls = fpsp_pkg::C_END;
         endcase
      end
   end

endmodule

[design/fpsp_engine.sv]
// ----------------------------------------------------------------------------
// fpsp_engine
// Parse state, argument counter and token record, with the transition table
// and the record update for one item. The result is combinational; the
// state advances on step.
// ----------------------------------------------------------------------------
module fpsp_engine #(
   parameter int ARG_INDEX_BITS = fpsp_pkg::ARG_INDEX_BITS_DEF,
   parameter int CHAR_TABLE_LEN = fpsp_pkg::CHAR_TABLE_LEN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [fpsp_pkg::KIND_BITS-1:0] kind,
   input  logic [fpsp_pkg::CODE_BITS-1:0] code,
   output fpsp_pkg::parse_result_type     result
);

   typedef enum logic [2:0] {
      S_STR, S_FMT, S_FLAG, S_WIDTH, S_PREC, S_SIZE
   } state_type;

   typedef enum logic [3:0] {
      A_NONE, A_START, A_ESC, A_FLAG, A_SETW, A_W, A_VARW,
      A_SETP, A_P, A_VARP, A_SIZE, A_ERR, A_END
   } action_type;

   function automatic state_type next_of(state_type s, fpsp_pkg::char_class_type c);
      state_type n;
      n = S_STR;
      unique case (s)
         S_STR: begin
            if (c == fpsp_pkg::C_PCT) n = S_FMT;
         end
         S_FMT, S_FLAG: begin
            case (c) inside
               fpsp_pkg::C_FLAG, fpsp_pkg::C_ZERO: n = S_FLAG;
               fpsp_pkg::C_NUM, fpsp_pkg::C_STAR:  n = S_WIDTH;
               fpsp_pkg::C_DOT:                    n = S_PREC;
               fpsp_pkg::C_SIZE:                   n = S_SIZE;
               default:                            n = S_STR;
            endcase
         end
         S_WIDTH: begin
            case (c) inside
               fpsp_pkg::C_NUM, fpsp_pkg::C_STAR, fpsp_pkg::C_ZERO: n = S_WIDTH;
               fpsp_pkg::C_DOT:                                     n = S_PREC;
               fpsp_pkg::C_SIZE:                                    n = S_SIZE;
               default:                                             n = S_STR;
            endcase
         end
         S_PREC: begin
            case (c) inside
               fpsp_pkg::C_NUM, fpsp_pkg::C_STAR, fpsp_pkg::C_ZERO: n = S_PREC;
               fpsp_pkg::C_SIZE:                                    n = S_SIZE;
               default:                                             n = S_STR;
            endcase
         end
         S_SIZE: begin
            if (c == fpsp_pkg::C_SIZE) n = S_SIZE;
         end
         default: n = S_STR;
      endcase
      return n;
   endfunction

   function automatic action_type action_of(state_type s, fpsp_pkg::char_class_type c);
      action_type a;
      a = A_ERR;
      unique case (s)
         S_STR: begin
            a = (c == fpsp_pkg::C_PCT) ? A_START : A_NONE;
         end
         S_FMT, S_FLAG: begin
            case (c) inside
               fpsp_pkg::C_PCT:                    a = (s == S_FMT) ? A_ESC : A_ERR;
               fpsp_pkg::C_FLAG, fpsp_pkg::C_ZERO: a = A_FLAG;
               fpsp_pkg::C_NUM:                    a = A_SETW;
               fpsp_pkg::C_STAR:                   a = A_VARW;
               fpsp_pkg::C_DOT:                    a = A_SETP;
               fpsp_pkg::C_SIZE:                   a = A_SIZE;
               fpsp_pkg::C_TYPE:                   a = A_END;
               default:                            a = A_ERR;
            endcase
         end
         S_WIDTH: begin
            case (c) inside
               fpsp_pkg::C_NUM, fpsp_pkg::C_ZERO: a = A_W;
               fpsp_pkg::C_STAR:                  a = A_VARW;
               fpsp_pkg::C_DOT:                   a = A_SETP;
               fpsp_pkg::C_SIZE:                  a = A_SIZE;
               fpsp_pkg::C_TYPE:                  a = A_END;
               default:                           a = A_ERR;
            endcase
         end
         S_PREC: begin
            // A second dot closes the specifier as a conversion.
            case (c) inside
               fpsp_pkg::C_NUM, fpsp_pkg::C_ZERO: a = A_P;
               fpsp_pkg::C_STAR:                  a = A_VARP;
               fpsp_pkg::C_DOT, fpsp_pkg::C_TYPE: a = A_END;
               fpsp_pkg::C_SIZE:                  a = A_SIZE;
               default:                           a = A_ERR;
            endcase
         end
         S_SIZE: begin
            case (c) inside
               fpsp_pkg::C_SIZE: a = A_SIZE;
               fpsp_pkg::C_TYPE: a = A_END;
               default:          a = A_ERR;
            endcase
         end
         default: a = A_ERR;
      endcase
      return a;
   endfunction

   // Decimal accumulation v * 10 + d, saturating at the 16-bit maximum.
   function automatic logic [15:0] accumulate(logic [15:0] v, logic [3:0] d);
      logic [19:0] n;
      n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {16'b0, d};
      return (n > {4'b0, fpsp_pkg::VALUE_MAX}) ? fpsp_pkg::VALUE_MAX : n[15:0];
   endfunction

   state_type                  state_ff, state_in;
   logic [ARG_INDEX_BITS-1:0]  count_ff, count_in;
   fpsp_pkg::token_record_type rec_ff, rec_in;
   fpsp_pkg::char_class_type   cls;
   action_type                 act;
   logic [ARG_INDEX_BITS+fpsp_pkg::ARG_FIELD_BITS-1:0] count_ext;
   logic [fpsp_pkg::ARG_FIELD_BITS-1:0]                arg_idx;
   logic [6:0]                 ch;
   logic [3:0]                 digit;
   logic                       emit, incl;

   fpsp_classify #(
      .CHAR_TABLE_LEN(CHAR_TABLE_LEN)
   ) u_classify (
      .code(code),
      .cls (cls)
   );

   // Argument indices are the low bits of the counter, zero-extended when
   // the counter is narrower than the field.
   assign count_ext = {{fpsp_pkg::ARG_FIELD_BITS{1'b0}}, count_ff};
   assign arg_idx   = count_ext[fpsp_pkg::ARG_FIELD_BITS-1:0];
   assign ch        = code[6:0];
   assign digit     = code[3:0];
   assign act       = action_of(state_ff, cls);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rec_in   = rec_ff;
      emit     = 1'b0;
      incl     = 1'b0;
      unique case (kind)
         fpsp_pkg::KIND_END: begin
            rec_in.token_type = fpsp_pkg::TT_LITERAL;
            emit              = 1'b1;
         end
         fpsp_pkg::KIND_RESTART: begin
            state_in = S_STR;
            count_in = '0;
         end
         fpsp_pkg::KIND_CHAR: begin
            state_in = next_of(state_ff, cls);
            case (act)
               A_START: begin
                  rec_in.token_type     = fpsp_pkg::TT_LITERAL;
                  rec_in.size_mod       = fpsp_pkg::SZ_NORMAL;
                  rec_in.width_mode     = fpsp_pkg::MODE_DEFAULT;
                  rec_in.precision_mode = fpsp_pkg::MODE_DEFAULT;
                  rec_in.flag_bits      = '0;
                  emit                  = 1'b1;
               end
               A_ESC: begin
                  rec_in.token_type = fpsp_pkg::TT_ESCAPE;
                  emit              = 1'b1;
                  incl              = 1'b1;
               end
               A_FLAG: begin
                  case (ch)
                     fpsp_pkg::CH_MINUS: rec_in.flag_bits[fpsp_pkg::FLAG_LEFT]  = 1'b1;
                     fpsp_pkg::CH_PLUS:  rec_in.flag_bits[fpsp_pkg::FLAG_PLUS]  = 1'b1;
                     fpsp_pkg::CH_SPACE: rec_in.flag_bits[fpsp_pkg::FLAG_SPACE] = 1'b1;
                     fpsp_pkg::CH_ZERO:  rec_in.flag_bits[fpsp_pkg::FLAG_ZERO]  = 1'b1;
                     fpsp_pkg::CH_HASH:  rec_in.flag_bits[fpsp_pkg::FLAG_ALT]   = 1'b1;
                     default: ;
                  endcase
               end
               A_SETW: begin
                  rec_in.width_mode  = fpsp_pkg::MODE_LITERAL;
                  rec_in.width_value = {12'b0, digit};
               end
               A_W: rec_in.width_value = accumulate(rec_ff.width_value, digit);
               A_VARW: begin
                  rec_in.width_mode = fpsp_pkg::MODE_ARG;
                  rec_in.width_arg  = arg_idx;
                  count_in          = count_ff + ARG_INDEX_BITS'(1);
               end
               A_SETP: begin
                  rec_in.precision_mode  = fpsp_pkg::MODE_LITERAL;
                  rec_in.precision_value = '0;
               end
               A_P: rec_in.precision_value = accumulate(rec_ff.precision_value, digit);
               A_VARP: begin
                  rec_in.precision_mode = fpsp_pkg::MODE_ARG;
                  rec_in.precision_arg  = arg_idx;
                  count_in              = count_ff + ARG_INDEX_BITS'(1);
               end
               A_SIZE: begin
                  case (ch)
                     fpsp_pkg::CH_H: rec_in.size_mod =
                        (rec_ff.size_mod == fpsp_pkg::SZ_H) ? fpsp_pkg::SZ_HH : fpsp_pkg::SZ_H;
                     fpsp_pkg::CH_L: rec_in.size_mod =
                        (rec_ff.size_mod == fpsp_pkg::SZ_L) ? fpsp_pkg::SZ_LL : fpsp_pkg::SZ_L;
                     fpsp_pkg::CH_UL: rec_in.size_mod = fpsp_pkg::SZ_BIG_L;
                     fpsp_pkg::CH_Z:  rec_in.size_mod = fpsp_pkg::SZ_Z;
                     fpsp_pkg::CH_J:  rec_in.size_mod = fpsp_pkg::SZ_J;
                     fpsp_pkg::CH_T:  rec_in.size_mod = fpsp_pkg::SZ_T;
                     default: ;
                  endcase
               end
               A_ERR: begin
                  rec_in.token_type = fpsp_pkg::TT_LITERAL;
                  emit              = 1'b1;
               end
               A_END: begin
                  // Letters not listed (a closing dot) keep the current type.
                  case (ch)
                     fpsp_pkg::CH_D, fpsp_pkg::CH_I: rec_in.token_type = fpsp_pkg::TT_SDEC;
                     fpsp_pkg::CH_O: rec_in.token_type = fpsp_pkg::TT_OCT;
                     fpsp_pkg::CH_U: rec_in.token_type = fpsp_pkg::TT_UDEC;
                     fpsp_pkg::CH_X: begin
                        rec_in.token_type                    = fpsp_pkg::TT_HEX;
                        rec_in.flag_bits[fpsp_pkg::FLAG_UPPER] = 1'b0;
                     end
                     fpsp_pkg::CH_UX: begin
                        rec_in.token_type                    = fpsp_pkg::TT_HEX;
                        rec_in.flag_bits[fpsp_pkg::FLAG_UPPER] = 1'b1;
                     end
                     fpsp_pkg::CH_F, fpsp_pkg::CH_UF: rec_in.token_type = fpsp_pkg::TT_F;
                     fpsp_pkg::CH_E: begin
                        rec_in.token_type                    = fpsp_pkg::TT_E;
                        rec_in.flag_bits[fpsp_pkg::FLAG_UPPER] = 1'b0;
                     end
                     fpsp_pkg::CH_UE: begin
                        rec_in.token_type                    = fpsp_pkg::TT_E;
                        rec_in.flag_bits[fpsp_pkg::FLAG_UPPER] = 1'b1;
                     end
                     fpsp_pkg::CH_G: begin
                        rec_in.token_type                    = fpsp_pkg::TT_G;
                        rec_in.flag_bits[fpsp_pkg::FLAG_UPPER] = 1'b0;
                     end
                     fpsp_pkg::CH_UG: begin
                        rec_in.token_type                    = fpsp_pkg::TT_G;
                        rec_in.flag_bits[fpsp_pkg::FLAG_UPPER] = 1'b1;
                     end
                     fpsp_pkg::CH_A: begin
                        rec_in.token_type                    = fpsp_pkg::TT_A;
                        rec_in.flag_bits[fpsp_pkg::FLAG_UPPER] = 1'b0;
                     end
                     fpsp_pkg::CH_UA: begin
                        rec_in.token_type                    = fpsp_pkg::TT_A;
                        rec_in.flag_bits[fpsp_pkg::FLAG_UPPER] = 1'b1;
                     end
                     fpsp_pkg::CH_C: rec_in.token_type = fpsp_pkg::TT_C;
                     fpsp_pkg::CH_S: rec_in.token_type = fpsp_pkg::TT_S;
                     fpsp_pkg::CH_P: rec_in.token_type = fpsp_pkg::TT_P;
                     fpsp_pkg::CH_N: rec_in.token_type = fpsp_pkg::TT_N;
                     default: ;
                  endcase
                  rec_in.value_arg = arg_idx;
                  count_in         = count_ff + ARG_INDEX_BITS'(1);
                  emit             = 1'b1;
                  incl             = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign result.emit         = emit;
   assign result.include_char = incl;
   assign result.rec          = rec_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_STR;
         count_ff <= '0;
         rec_ff   <= '0;
      end else if (step) begin
         state_ff <= state_in;
         count_ff <= count_in;
         rec_ff   <= rec_in;
      end
   end

endmodule

[design/printf_format_spec_parser_unit.sv]
// ----------------------------------------------------------------------------
// printf_format_spec_parser_unit
// Path: an accepted item is held in the input register; its parse result is
// then loaded into the result register, from which it is shown.
// Throughput: one item per cycle unless the result side stalls.
// Reset: synchronous; both registers empty, parser in plain string state,
// argument counter zero, token record all zero.
// ----------------------------------------------------------------------------
module printf_format_spec_parser_unit #(
   parameter int ARG_INDEX_BITS = fpsp_pkg::ARG_INDEX_BITS_DEF,
   parameter int CHAR_TABLE_LEN = fpsp_pkg::CHAR_TABLE_LEN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // code [20:0], zero padding [23:21]
   input  logic [fpsp_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // kind [1:0]
   input  logic [fpsp_pkg::REQ_TUSER_BITS-1:0] req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // token_type [3:0], flag_bits [9:4], size_mod [13:10], width_value [29:14],
   // width_mode [31:30], width_arg [39:32], precision_value [55:40],
   // precision_mode [57:56], precision_arg [65:58], value_arg [73:66],
   // zero padding [79:74]
   output logic [fpsp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // emit [0], include_char [1]
   output logic [fpsp_pkg::RSP_TUSER_BITS-1:0] rsp_tuser
);

   // The input register takes one transfer per cycle unless stalled. Its item
   // goes to the parse engine whenever the result register is free or being
   // drained in the same cycle; the engine's state advances at that edge, so
   // the result register always holds the record of the last parsed item.

   logic                           in_valid_ff, in_valid_in;
   logic [fpsp_pkg::KIND_BITS-1:0] in_kind_ff;
   logic [fpsp_pkg::CODE_BITS-1:0] in_code_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   fpsp_pkg::parse_result_type     rsp_res_ff;
   fpsp_pkg::parse_result_type     eng_result;
   logic                           advance;
   logic                           req_take;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_tuser[fpsp_pkg::KIND_BITS-1:0];
         in_code_ff <= req_tdata[fpsp_pkg::CODE_BITS-1:0];
      end
      if (advance) begin
         rsp_res_ff <= eng_result;
      end
   end

   fpsp_engine #(
      .ARG_INDEX_BITS(ARG_INDEX_BITS),
      .CHAR_TABLE_LEN(CHAR_TABLE_LEN)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .kind  (in_kind_ff),
      .code  (in_code_ff),
      .result(eng_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_res_ff.include_char, rsp_res_ff.emit};
   assign rsp_tdata  = {6'b0, rsp_res_ff.rec};

endmodule

[design/fpsp_checker.sv]
// ----------------------------------------------------------------------------
// fpsp_checker
// Port-level checks of the parser unit, attached to it by a bind.
// ----------------------------------------------------------------------------
module fpsp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [fpsp_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input logic [fpsp_pkg::REQ_TUSER_BITS-1:0] req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [fpsp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic [fpsp_pkg::RSP_TUSER_BITS-1:0] rsp_tuser
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Nothing is shown in the cycle after a reset edge.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The input side never waits while the result side can take a transfer.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while output is free");

   // A character can only belong to a token that is being emitted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("include_char without emit");

   // Record fields stay within their codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] <= fpsp_pkg::TT_N
                  && rsp_tdata[13:10] <= fpsp_pkg::SZ_T
                  && rsp_tdata[31:30] != fpsp_pkg::MODE_UNUSED
                  && rsp_tdata[57:56] != fpsp_pkg::MODE_UNUSED)
      else $error("record field out of range");

   logic unused_inputs;
   assign unused_inputs = req_tvalid ^ (^req_tdata) ^ (^req_tuser);

endmodule

bind printf_format_spec_parser_unit fpsp_checker u_fpsp_checker (.*);

[verif/tb_printf_format_spec_parser_unit.sv]
// ----------------------------------------------------------------------------
// tb_printf_format_spec_parser_unit
// Self-checking testbench for the printf format specifier parser. A
// cycle-free model of the parse engine predicts the token record, the emit
// flag and the include flag for every accepted input transfer. A checker
// compares each result transfer, field by field, against the oldest
// prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_printf_format_spec_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import fpsp_pkg::*;

   // The input kind that the block must ignore.
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
   localparam int MAX_SHOWN = 10;

   // Parse phases of the model, in the order of a specifier's grammar.
   typedef enum logic [2:0] {
      PH_TEXT, PH_PERCENT, PH_FLAGS, PH_WIDTH, PH_PRECISION, PH_SIZE
   } parse_phase_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [REQ_TUSER_BITS-1:0] req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [RSP_TUSER_BITS-1:0] rsp_tuser;

   // When set, neither side idles; this gives a long back-to-back stretch.
   logic steady_flow = 1'b0;

   // Model state: the parse phase, the argument counter and the token record.
   parse_phase_type  model_phase = PH_TEXT;
   logic [7:0]       model_arg_count = '0;
   token_record_type model_rec = '0;

   // Predicted results, oldest first.
   parse_result_type expected_tokens[$];

   int error_count = 0;
   int item_count = 0;
   int result_count = 0;
   int conversion_count = 0;

   printf_format_spec_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A generous ceiling: the full run needs well under a tenth of this.
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Model of the parse engine
   // ------------------------------------------------------------------------

   // Character classes as the transition table sees them. Anything past the
   // table, and any code without a role, is plain text.
   function automatic char_class_type classify_code(input logic [CODE_BITS-1:0] code);
      logic [6:0] ch;
      ch = code[6:0];
      if (code >= CHAR_TABLE_LEN_DEF)
         return C_END;
      case (ch)
         CH_SPACE, CH_HASH, CH_PLUS, CH_MINUS: return C_FLAG;
         CH_PCT:  return C_PCT;
         CH_STAR: return C_STAR;
         CH_DOT:  return C_DOT;
         CH_ZERO: return C_ZERO;
         CH_UL, CH_H, CH_J, CH_L, CH_T, CH_Z: return C_SIZE;
         CH_UA, CH_UE, CH_UF, CH_UG, CH_UX, CH_A, CH_C, CH_D, CH_E, CH_F,
         CH_G, CH_I, CH_N, CH_O, CH_P, CH_S, CH_U, CH_X: return C_TYPE;
         default: ;
      endcase
      if (ch >= CH_ONE && ch <= CH_NINE)
         return C_NUM;
      return C_END;
   endfunction

   // Hands out the next argument number; the counter wraps at 8 bits.
   function automatic logic [7:0] next_arg();
      logic [7:0] arg;
      arg = model_arg_count;
      model_arg_count = model_arg_count + 8'd1;
      return arg;
   endfunction

   function automatic logic [15:0] accumulate_decimal(input logic [15:0] value,
                                                      input logic [3:0] digit);
      int unsigned sum;
      sum = 32'(value) * 10 + 32'(digit);
      return (sum > 32'(VALUE_MAX)) ? VALUE_MAX : sum[15:0];
   endfunction

   task automatic add_flag(input logic [6:0] ch);
      case (ch)
         CH_MINUS: model_rec.flag_bits[FLAG_LEFT]  = 1'b1;
         CH_PLUS:  model_rec.flag_bits[FLAG_PLUS]  = 1'b1;
         CH_SPACE: model_rec.flag_bits[FLAG_SPACE] = 1'b1;
         CH_ZERO:  model_rec.flag_bits[FLAG_ZERO]  = 1'b1;
         CH_HASH:  model_rec.flag_bits[FLAG_ALT]   = 1'b1;
         default: ;
      endcase
   endtask

   // A repeated h or l doubles the modifier; any other letter replaces it.
   task automatic apply_size(input logic [6:0] ch);
      case (ch)
         CH_H:  model_rec.size_mod = (model_rec.size_mod == SZ_H) ? SZ_HH : SZ_H;
         CH_L:  model_rec.size_mod = (model_rec.size_mod == SZ_L) ? SZ_LL : SZ_L;
         CH_UL: model_rec.size_mod = SZ_BIG_L;
         CH_Z:  model_rec.size_mod = SZ_Z;
         CH_J:  model_rec.size_mod = SZ_J;
         CH_T:  model_rec.size_mod = SZ_T;
         default: ;
      endcase
   endtask

   // Closes a specifier with a conversion. A second dot lands here too and
   // leaves the type as it was, but it still consumes an argument.
   task automatic finish_spec(input logic [6:0] ch, inout parse_result_type res);
      case (ch)
         CH_D, CH_I: model_rec.token_type = TT_SDEC;
         CH_O:       model_rec.token_type = TT_OCT;
         CH_U:       model_rec.token_type = TT_UDEC;
         CH_F, CH_UF: model_rec.token_type = TT_F;
         CH_C:       model_rec.token_type = TT_C;
         CH_S:       model_rec.token_type = TT_S;
         CH_P:       model_rec.token_type = TT_P;
         CH_N:       model_rec.token_type = TT_N;
         CH_X, CH_UX: begin
            model_rec.token_type = TT_HEX;
            model_rec.flag_bits[FLAG_UPPER] = (ch == CH_UX);
         end
         CH_E, CH_UE: begin
            model_rec.token_type = TT_E;
            model_rec.flag_bits[FLAG_UPPER] = (ch == CH_UE);
         end
         CH_G, CH_UG: begin
            model_rec.token_type = TT_G;
            model_rec.flag_bits[FLAG_UPPER] = (ch == CH_UG);
         end
         CH_A, CH_UA: begin
            model_rec.token_type = TT_A;
            model_rec.flag_bits[FLAG_UPPER] = (ch == CH_UA);
         end
         default: ;
      endcase
      model_rec.value_arg = next_arg();
      res.emit = 1'b1;
      res.include_char = 1'b1;
      model_phase = PH_TEXT;
   endtask

   // A character that does not fit the specifier turns it back into text.
   task automatic abort_spec(inout parse_result_type res);
      model_rec.token_type = TT_LITERAL;
      res.emit = 1'b1;
      model_phase = PH_TEXT;
   endtask

   // Advances the model by one accepted input transfer and queues the result.
   task automatic predict_token(input logic [KIND_BITS-1:0] kind,
                                input logic [CODE_BITS-1:0] code);
      parse_result_type res;
      char_class_type   cls;
      logic [6:0]       ch;
      logic [3:0]       digit;
      res = '0;
      ch = code[6:0];
      digit = code[3:0];
      case (kind)
         KIND_END: begin
            model_rec.token_type = TT_LITERAL;
            res.emit = 1'b1;
         end
         KIND_RESTART: begin
            model_phase = PH_TEXT;
            model_arg_count = '0;
         end
         KIND_CHAR: begin
            cls = classify_code(code);
            case (model_phase)
               PH_PERCENT, PH_FLAGS: begin
                  case (cls)
                     C_PCT: begin
                        if (model_phase == PH_PERCENT) begin
                           model_rec.token_type = TT_ESCAPE;
                           res.emit = 1'b1;
                           res.include_char = 1'b1;
                           model_phase = PH_TEXT;
                        end else begin
                           abort_spec(res);
                        end
                     end
                     C_FLAG, C_ZERO: begin
                        add_flag(ch);
                        model_phase = PH_FLAGS;
                     end
                     C_NUM: begin
                        model_rec.width_mode = MODE_LITERAL;
                        model_rec.width_value = 16'(digit);
                        model_phase = PH_WIDTH;
                     end
                     C_STAR: begin
                        model_rec.width_mode = MODE_ARG;
                        model_rec.width_arg = next_arg();
                        model_phase = PH_WIDTH;
                     end
                     C_DOT: begin
                        model_rec.precision_mode = MODE_LITERAL;
                        model_rec.precision_value = '0;
                        model_phase = PH_PRECISION;
                     end
                     C_SIZE: begin
                        apply_size(ch);
                        model_phase = PH_SIZE;
                     end
                     C_TYPE: finish_spec(ch, res);
                     default: abort_spec(res);
                  endcase
               end
               PH_WIDTH: begin
                  case (cls)
                     // Digits after a star still accumulate; the mode stays.
                     C_NUM, C_ZERO: model_rec.width_value =
                        accumulate_decimal(model_rec.width_value, digit);
                     C_STAR: begin
                        model_rec.width_mode = MODE_ARG;
                        model_rec.width_arg = next_arg();
                     end
                     C_DOT: begin
                        model_rec.precision_mode = MODE_LITERAL;
                        model_rec.precision_value = '0;
                        model_phase = PH_PRECISION;
                     end
                     C_SIZE: begin
                        apply_size(ch);
                        model_phase = PH_SIZE;
                     end
                     C_TYPE: finish_spec(ch, res);
                     default: abort_spec(res);
                  endcase
               end
               PH_PRECISION: begin
                  case (cls)
                     C_NUM, C_ZERO: model_rec.precision_value =
                        accumulate_decimal(model_rec.precision_value, digit);
                     C_STAR: begin
                        model_rec.precision_mode = MODE_ARG;
                        model_rec.precision_arg = next_arg();
                     end
                     C_SIZE: begin
                        apply_size(ch);
                        model_phase = PH_SIZE;
                     end
                     C_TYPE, C_DOT: finish_spec(ch, res);
                     default: abort_spec(res);
                  endcase
               end
               PH_SIZE: begin
                  case (cls)
                     C_SIZE: apply_size(ch);
                     C_TYPE: finish_spec(ch, res);
                     default: abort_spec(res);
                  endcase
               end
               default: begin
                  // Plain text: only a percent sign opens a specifier. The
                  // numbers and argument fields survive from the last one.
                  if (cls == C_PCT) begin
                     model_rec.token_type = TT_LITERAL;
                     model_rec.size_mod = SZ_NORMAL;
                     model_rec.width_mode = MODE_DEFAULT;
                     model_rec.precision_mode = MODE_DEFAULT;
                     model_rec.flag_bits = '0;
                     res.emit = 1'b1;
                     model_phase = PH_PERCENT;
                  end
               end
            endcase
         end
         default: ;
      endcase
      res.rec = model_rec;
      expected_tokens.push_back(res);
   endtask

   // ------------------------------------------------------------------------
   // Result side: random back-pressure and the checker
   // ------------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_SHOWN)
            $display("MISMATCH result %0d, %s: expected 0x%0h, got 0x%0h",
                     result_count, name, want, got);
      end
   endtask

   task automatic check_result();
      parse_result_type want;
      token_record_type got;
      got = token_record_type'(rsp_tdata[$bits(token_record_type)-1:0]);
      if (expected_tokens.size() == 0) begin
         error_count++;
         if (error_count <= MAX_SHOWN)
            $display("MISMATCH result %0d arrived with nothing outstanding",
                     result_count);
      end else begin
         want = expected_tokens.pop_front();
         compare_field("emit", 16'(want.emit), 16'(rsp_tuser[0]));
         compare_field("include_char", 16'(want.include_char), 16'(rsp_tuser[1]));
         compare_field("token_type", 16'(want.rec.token_type), 16'(got.token_type));
         compare_field("flag_bits", 16'(want.rec.flag_bits), 16'(got.flag_bits));
         compare_field("size_mod", 16'(want.rec.size_mod), 16'(got.size_mod));
         compare_field("width_value", want.rec.width_value, got.width_value);
         compare_field("width_mode", 16'(want.rec.width_mode), 16'(got.width_mode));
         compare_field("width_arg", 16'(want.rec.width_arg), 16'(got.width_arg));
         compare_field("precision_value", want.rec.precision_value,
                       got.precision_value);
         compare_field("precision_mode", 16'(want.rec.precision_mode),
                       16'(got.precision_mode));
         compare_field("precision_arg", 16'(want.rec.precision_arg),
                       16'(got.precision_arg));
         compare_field("value_arg", 16'(want.rec.value_arg), 16'(got.value_arg));
         if (want.emit && want.include_char)
            conversion_count++;
      end
      result_count++;
   endtask

   // Outputs are sampled at the edge, before any flop of this step updates.
   // The ready for the next edge is chosen afterwards.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_result();
      rsp_tready <= steady_flow || ($urandom_range(99) >= 24);
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offers one item and returns on the edge where the transfer happens.
   // Valid stays high afterwards so that the next item follows without a gap;
   // every wait that follows lowers it first.
   task automatic send_item(input logic [KIND_BITS-1:0] kind,
                            input logic [CODE_BITS-1:0] code);
      if (!steady_flow && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_BITS-CODE_BITS){1'b0}}, code};
      do @(posedge clock); while (!req_tready);
      item_count++;
      predict_token(kind, code);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_item(KIND_CHAR, 21'(text[i]));
   endtask

   // Stops offering input and waits until every predicted result has come.
   task automatic wait_for_drain();
      int cycles;
      cycles = 0;
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0 && cycles < 2000) begin
         @(posedge clock);
         cycles++;
      end
   endtask

   task automatic send_digits(input int count, input bit leading_nonzero);
      for (int i = 0; i < count; i++)
         send_item(KIND_CHAR, (i == 0 && leading_nonzero) ?
                   21'($urandom_range(CH_NINE, CH_ONE)) :
                   21'($urandom_range(CH_NINE, CH_ZERO)));
   endtask

   function automatic logic [CODE_BITS-1:0] random_text_code();
      if ($urandom_range(9) == 0)
         return 21'($urandom);
      return 21'($urandom_range(126, 32));
   endfunction

   // One specifier of random content: text, flags, width, precision, size
   // letters and a conversion. A few end in a broken or unusual way.
   task automatic send_random_spec();
      string flag_chars;
      string size_chars;
      string conv_chars;
      int    pick;
      flag_chars = " #+-0";
      size_chars = "hlLzjth";
      conv_chars = "AEFGXacdefginopsux";
      repeat ($urandom_range(2, 0)) send_item(KIND_CHAR, random_text_code());
      send_item(KIND_CHAR, 21'(CH_PCT));
      if ($urandom_range(11) == 0) begin
         send_item(KIND_CHAR, 21'(CH_PCT));
         return;
      end
      repeat ($urandom_range(3, 0))
         send_item(KIND_CHAR, 21'(flag_chars[$urandom_range(4)]));
      pick = $urandom_range(3);
      if (pick == 1) begin
         send_item(KIND_CHAR, 21'(CH_STAR));
         if ($urandom_range(4) == 0)
            send_digits($urandom_range(2, 1), 1'b0);
      end else if (pick >= 2) begin
         send_digits($urandom_range(7, 1), 1'b1);
      end
      if ($urandom_range(1) == 0) begin
         send_item(KIND_CHAR, 21'(CH_DOT));
         if ($urandom_range(3) == 0)
            send_item(KIND_CHAR, 21'(CH_STAR));
         else
            send_digits($urandom_range(6, 0), 1'b0);
      end
      repeat ($urandom_range(2, 0))
         send_item(KIND_CHAR, 21'(size_chars[$urandom_range(6)]));
      pick = $urandom_range(19);
      case (pick)
         0: send_item(KIND_CHAR, 21'(CH_DOT));
         1: send_item(KIND_CHAR, 21'(CH_PCT));
         2: send_item(KIND_END, 21'($urandom));
         3: send_item(KIND_RESTART, 21'($urandom));
         4: send_item(KIND_CHAR, random_text_code());
         default: send_item(KIND_CHAR, 21'(conv_chars[$urandom_range(17)]));
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Text, the opening percent sign and the percent escape.
   task automatic test_escape();
      send_text("a%%");
   endtask

   // Every flag, width and precision from arguments, a doubled size letter and
   // an upper-case conversion.
   task automatic test_full_specifier();
      send_text("%-+ #0*.*hhX");
   endtask

   // Digits after a star keep accumulating, the width saturates, and a second
   // dot closes the specifier with its old type.
   task automatic test_star_digits_and_saturation();
      send_text("%*79999..");
   endtask

   // A character past the class table breaks a specifier; then end of
   // string, restart and the unused kind, all with extreme codes.
   task automatic test_stream_control();
      send_text("%h");
      send_item(KIND_CHAR, 21'(CHAR_TABLE_LEN_DEF));
      send_item(KIND_END, 21'h1FFFFF);
      send_item(KIND_RESTART, 21'h0AAAAA);
      send_item(KIND_UNUSED, 21'h155555);
   endtask

   // Back-to-back specifiers that take three arguments each, with no idling
   // on either side, so the argument counter wraps past 255.
   task automatic test_argument_wrap();
      string conv_chars;
      conv_chars = "AEFGXacdefginopsux";
      steady_flow <= 1'b1;
      send_item(KIND_RESTART, 21'($urandom));
      repeat (90) begin
         send_text("%*.*");
         if ($urandom_range(1) == 0)
            send_item(KIND_CHAR, 21'(CH_L));
         send_item(KIND_CHAR, 21'(conv_chars[$urandom_range(17)]));
      end
      steady_flow <= 1'b0;
   endtask

   task automatic test_random_specifiers();
      repeat (70) send_random_spec();
   endtask

   // Noise: any kind and any code, biased toward characters that matter.
   task automatic test_random_noise();
      string special_chars;
      int    pick;
      special_chars = " #%*+-.0123456789AEFGLXacdefghijlnopstuxz";
      repeat (150) begin
         pick = $urandom_range(99);
         if (pick < 6)
            send_item(KIND_END, 21'($urandom));
         else if (pick < 10)
            send_item(KIND_RESTART, 21'($urandom));
         else if (pick < 13)
            send_item(KIND_UNUSED, 21'($urandom));
         else if (pick < 50)
            send_item(KIND_CHAR,
                      21'(special_chars[$urandom_range(special_chars.len() - 1)]));
         else if (pick < 80)
            send_item(KIND_CHAR, 21'($urandom_range(127, 0)));
         else
            send_item(KIND_CHAR, 21'($urandom));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_escape();
      test_full_specifier();
      test_star_digits_and_saturation();
      test_stream_control();
      // The sender holds off here until the block has answered everything.
      wait_for_drain();
      test_argument_wrap();
      test_random_specifiers();
      wait_for_drain();
      test_random_noise();
      wait_for_drain();

      // A further wait after the drain catches any stray transfer.
      repeat (8) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         error_count += expected_tokens.size();
         $display("%0d predicted results never arrived", expected_tokens.size());
      end

      $display("Sent %0d items (text, specifiers, escapes, end, restart, noise);",
               item_count);
      $display("checked %0d results, %0d closing a token, %0d errors.",
               result_count, conversion_count, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
design/fpsp_pkg.sv
design/fpsp_classify.sv
design/fpsp_engine.sv
design/printf_format_spec_parser_unit.sv
design/fpsp_checker.sv
verif/tb_printf_format_spec_parser_unit.sv
